// ----- src/quaternion_to_euler_angles_unit_defines.svh -----
// assertion macros for the quaternion to euler angles unit
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define QTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qte assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define QTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qte assertion failed");
`else
`define QTE_ASSERT_IMP(lbl, ante, cons)
`define QTE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- src/qte_pkg.sv -----
package qte_pkg;

  // cordic depth and square root depth
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_N       = 24;
  localparam int STEP_W       = 5;
  localparam int SQRT_STEPS   = 29;

  // field widths
  localparam int QW      = 16;
  localparam int ANG_W   = 16;
  localparam int PITCH_W = 15;
  localparam int THR_W   = 15;
  localparam int CFG_IDX_W = 1;

  // internal widths
  localparam int PROD_W = 32;
  localparam int ARG_W  = 34;
  localparam int CX_W   = 36;
  localparam int Z_W    = 24;
  localparam int RSQ_W  = 29;
  localparam int ROOT_W = 29;
  localparam int REM_W  = 31;
  localparam int RAD_W  = 58;

  // constants
  localparam logic signed [ARG_W-1:0] HALF_Q28    = 34'sd134217728;
  localparam logic signed [Z_W-1:0]   HALF_PI_Q20 = 24'sd1647099;
  localparam logic [16:0]             PI_Q13      = 17'd25736;
  localparam logic [16:0]             HALF_PI_Q13 = 17'd12868;
  localparam logic [THR_W-1:0]        THR_RESET   = 15'd16368;
  localparam logic signed [15:0]      ONE_Q14     = 16'sd16384;

  // arctangent table, q20 radians
  localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_N] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451, 24'sd32757,
    24'sd16383, 24'sd8192, 24'sd4096, 24'sd2048, 24'sd1024, 24'sd512,
    24'sd256, 24'sd128, 24'sd64, 24'sd32, 24'sd16, 24'sd8,
    24'sd4, 24'sd2, 24'sd1, 24'sd0, 24'sd0, 24'sd0
  };

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION_MODE = 1'b0,
    REG_LOCK_THRESHOLD = 1'b1
  } cfg_reg_t;

  // cordic channel slots
  localparam int CH_HEAD  = 0;
  localparam int CH_PITCH = 1;
  localparam int CH_BANK  = 2;

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } quat_t;

  // data that rides along the square root chain
  typedef struct packed {
    logic signed [ARG_W-1:0]   hy;
    logic signed [ARG_W-1:0]   hx;
    logic signed [ARG_W-1:0]   by;
    logic signed [ARG_W-1:0]   bx;
    logic signed [ARG_W-1:0]   py;
    logic                      locked;
    logic signed [PITCH_W-1:0] pitch_lock;
  } side_t;

  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    side_t             side;
  } sq_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
  } cch_t;

  typedef struct packed {
    logic                      valid;
    logic                      locked;
    logic signed [PITCH_W-1:0] pitch_lock;
    cch_t [2:0]                ch;
  } cd_t;

endpackage

// ----- src/qte_intf.sv -----
// quaternion input channel
interface qte_quat_if
  import qte_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] quat_w;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// euler angle result channel
interface qte_euler_if
  import qte_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [ANG_W-1:0]   heading_angle;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic signed [ANG_W-1:0]   bank_angle;
  logic                      gimbal_locked;

  modport source (output valid, heading_angle, pitch_angle, bank_angle, gimbal_locked,
                  input ready);
  modport sink (input valid, heading_angle, pitch_angle, bank_angle, gimbal_locked,
                output ready);
endinterface

// ----- src/qte_front.sv -----
module qte_front
  import qte_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  quat_t            quat,
  input  logic             dir_mode,
  input  logic [THR_W-1:0] lock_thr,
  output sq_t              sq_o
);

  // stage 1 products
  logic                      v1_r;
  logic signed [PROD_W-1:0]  wx_r, wy_r, wz_r, xy_r, xz_r, yz_r, xx_r, yy_r, zz_r;
  logic signed [PROD_W-1:0]  wx_m, wy_m, wz_m;

  assign wx_m = PROD_W'(quat.quat_w) * PROD_W'(quat.quat_x);
  assign wy_m = PROD_W'(quat.quat_w) * PROD_W'(quat.quat_y);
  assign wz_m = PROD_W'(quat.quat_w) * PROD_W'(quat.quat_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wx_r <= dir_mode ? -wx_m : wx_m;
      wy_r <= dir_mode ? -wy_m : wy_m;
      wz_r <= dir_mode ? -wz_m : wz_m;
      xy_r <= PROD_W'(quat.quat_x) * PROD_W'(quat.quat_y);
      xz_r <= PROD_W'(quat.quat_x) * PROD_W'(quat.quat_z);
      yz_r <= PROD_W'(quat.quat_y) * PROD_W'(quat.quat_z);
      xx_r <= PROD_W'(quat.quat_x) * PROD_W'(quat.quat_x);
      yy_r <= PROD_W'(quat.quat_y) * PROD_W'(quat.quat_y);
      zz_r <= PROD_W'(quat.quat_z) * PROD_W'(quat.quat_z);
    end
  end

  // stage 2 product sums and sine of pitch
  logic                     v2_r;
  logic signed [ARG_W-1:0]  hyl_r, hxl_r, hyu_r, hxu_r, by_r, bx_r;
  logic signed [15:0]       sp_r;
  logic signed [ARG_W-1:0]  t_sum;
  logic [ARG_W-1:0]         t_mag;
  logic [ARG_W-1:0]         t_rnd;
  logic signed [ARG_W-1:0]  sp_full;
  logic signed [15:0]       sp_nxt;

  always_comb begin
    t_sum = ARG_W'(yz_r) - ARG_W'(wx_r);
    t_mag = t_sum[ARG_W-1] ? ARG_W'(-t_sum) : ARG_W'(t_sum);
    t_rnd = (t_mag + ARG_W'(4096)) >> 13;
    sp_full = t_sum[ARG_W-1] ? $signed(t_rnd) : -$signed(t_rnd);
    if (sp_full > ARG_W'(ONE_Q14)) begin
      sp_nxt = ONE_Q14;
    end else if (sp_full < -ARG_W'(ONE_Q14)) begin
      sp_nxt = -ONE_Q14;
    end else begin
      sp_nxt = sp_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_r  <= sp_nxt;
      hyl_r <= ARG_W'(wy_r) - ARG_W'(xz_r);
      hxl_r <= HALF_Q28 - ARG_W'(yy_r) - ARG_W'(zz_r);
      hyu_r <= ARG_W'(xz_r) + ARG_W'(wy_r);
      hxu_r <= HALF_Q28 - ARG_W'(xx_r) - ARG_W'(yy_r);
      by_r  <= ARG_W'(xy_r) + ARG_W'(wz_r);
      bx_r  <= HALF_Q28 - ARG_W'(xx_r) - ARG_W'(zz_r);
    end
  end

  // stage 3 lock test, locked pitch and cosine radicand
  logic                      v3_r;
  logic                      lock_r;
  logic signed [PITCH_W-1:0] plock_r;
  logic [RSQ_W-1:0]          rsq_r;
  logic signed [ARG_W-1:0]   hy_r, hx_r, by3_r, bx3_r, py_r;
  logic signed [15:0]        sp_abs;
  logic                      lock_nxt;
  logic signed [30:0]        pl_prod;
  logic [30:0]               pl_mag;
  logic [30:0]               pl_rnd;
  logic signed [31:0]        sp_sq;
  logic signed [31:0]        rsq_full;

  always_comb begin
    sp_abs   = sp_r[15] ? -sp_r : sp_r;
    lock_nxt = sp_abs[THR_W-1:0] > lock_thr;
    pl_prod  = 31'(sp_r) * 31'sd12868;
    pl_mag   = pl_prod[30] ? 31'(-pl_prod) : 31'(pl_prod);
    pl_rnd   = (pl_mag + 31'd8192) >> 14;
    sp_sq    = 32'(sp_r) * 32'(sp_r);
    rsq_full = 32'sd268435456 - sp_sq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lock_r  <= lock_nxt;
      plock_r <= pl_prod[30] ? -$signed(pl_rnd[PITCH_W-1:0]) : $signed(pl_rnd[PITCH_W-1:0]);
      rsq_r   <= rsq_full[RSQ_W-1:0];
      hy_r    <= lock_nxt ? hyl_r : hyu_r;
      hx_r    <= lock_nxt ? hxl_r : hxu_r;
      by3_r   <= by_r;
      bx3_r   <= bx_r;
      py_r    <= ARG_W'(sp_r) <<< 14;
    end
  end

  // seed of the square root chain
  always_comb begin
    sq_o.valid           = v3_r;
    sq_o.rem             = '0;
    sq_o.root            = '0;
    sq_o.rad             = {1'b0, rsq_r, 28'd0};
    sq_o.side.hy         = hy_r;
    sq_o.side.hx         = hx_r;
    sq_o.side.by         = by3_r;
    sq_o.side.bx         = bx3_r;
    sq_o.side.py         = py_r;
    sq_o.side.locked     = lock_r;
    sq_o.side.pitch_lock = plock_r;
  end

endmodule

// ----- src/qte_sqrt_cell.sv -----
module qte_sqrt_cell
  import qte_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  sq_t  d,
  output sq_t  q
);

  logic             valid_r;
  sq_t              data_r;
  logic [REM_W+1:0] cur;
  logic [REM_W+2:0] trial;
  sq_t              data_nxt;

  // one result bit per cell: restoring digit step
  always_comb begin
    cur   = {d.rem, d.rad[RAD_W-1 -: 2]};
    trial = {1'b0, cur} - (REM_W+3)'({d.root, 2'b01});
    data_nxt      = d;
    data_nxt.rad  = d.rad << 2;
    if (!trial[REM_W+2]) begin
      data_nxt.rem  = trial[REM_W-1:0];
      data_nxt.root = {d.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_nxt.rem  = cur[REM_W-1:0];
      data_nxt.root = {d.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    q       = data_r;
    q.valid = valid_r;
  end

endmodule

// ----- src/qte_cordic_cell.sv -----
module qte_cordic_cell
  import qte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [STEP_W-1:0] step,
  input  cd_t               d,
  output cd_t               q
);

  logic valid_r;
  cd_t  data_r;
  cd_t  data_nxt;

  // one vectoring micro-rotation on each of the three channels
  always_comb begin
    data_nxt = d;
    for (int k = 0; k < 3; k++) begin
      if (d.ch[k].y > 0) begin
        data_nxt.ch[k].x = d.ch[k].x + (d.ch[k].y >>> step);
        data_nxt.ch[k].y = d.ch[k].y - (d.ch[k].x >>> step);
        data_nxt.ch[k].z = d.ch[k].z + ATAN_TAB[step];
      end else begin
        data_nxt.ch[k].x = d.ch[k].x - (d.ch[k].y >>> step);
        data_nxt.ch[k].y = d.ch[k].y + (d.ch[k].x >>> step);
        data_nxt.ch[k].z = d.ch[k].z - ATAN_TAB[step];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    q       = data_r;
    q.valid = valid_r;
  end

endmodule

// ----- src/quaternion_to_euler_angles_unit.sv -----
// pipeline from input accept to result valid: 3 front stages, 29 square root cells,
// 1 pre-rotation stage, CORDIC_STEPS cordic cells and 1 output register
// throughput: one item per cycle; the whole pipeline stalls only while a result waits
// reset: synchronous active-low rst_n clears all valid bits, direction_mode to 0 and
// lock_threshold to 16368
`include "quaternion_to_euler_angles_unit_defines.svh"
module quaternion_to_euler_angles_unit
  import qte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  qte_quat_if.sink             in_quat,
  qte_euler_if.source          out_euler,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_wdata
);

  logic             dir_mode_r;
  logic [THR_W-1:0] lock_thr_r;
  logic             adv;
  logic             out_valid_r;
  quat_t            quat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_mode_r <= 1'b0;
      lock_thr_r <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DIRECTION_MODE: dir_mode_r <= cfg_wdata[0];
        REG_LOCK_THRESHOLD: lock_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline moves when the output slot is free or being taken
  assign adv           = !out_valid_r || out_euler.ready;
  assign in_quat.ready = adv;

  assign quat.quat_w = in_quat.quat_w;
  assign quat.quat_x = in_quat.quat_x;
  assign quat.quat_y = in_quat.quat_y;
  assign quat.quat_z = in_quat.quat_z;

  sq_t sq_chain [SQRT_STEPS+1];

  qte_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_quat.valid),
    .quat     (quat),
    .dir_mode (dir_mode_r),
    .lock_thr (lock_thr_r),
    .sq_o     (sq_chain[0])
  );

  // square root chain for the pitch cosine
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d     (sq_chain[i]),
      .q     (sq_chain[i+1])
    );
  end

  // quadrant pre-rotation into the right half plane
  function automatic cch_t prerot(logic signed [ARG_W-1:0] sy, logic signed [ARG_W-1:0] sx);
    cch_t                   c;
    logic signed [CX_W-1:0] x0;
    logic signed [CX_W-1:0] y0;
    x0     = CX_W'(sx);
    y0     = CX_W'(sy);
    c.zero = (sx == '0) && (sy == '0);
    if (x0 < 0) begin
      if (y0 >= 0) begin
        c.x = y0;
        c.y = -x0;
        c.z = HALF_PI_Q20;
      end else begin
        c.x = -y0;
        c.y = x0;
        c.z = -HALF_PI_Q20;
      end
    end else begin
      c.x = x0;
      c.y = y0;
      c.z = '0;
    end
    return c;
  endfunction

  cd_t   cd_chain [CORDIC_STEPS+1];
  cd_t   pre_r;
  logic  pre_valid_r;
  cd_t   pre_nxt;
  side_t sd;

  always_comb begin
    sd                   = sq_chain[SQRT_STEPS].side;
    pre_nxt.valid        = sq_chain[SQRT_STEPS].valid;
    pre_nxt.locked       = sd.locked;
    pre_nxt.pitch_lock   = sd.pitch_lock;
    pre_nxt.ch[CH_HEAD]  = prerot(sd.hy, sd.hx);
    pre_nxt.ch[CH_PITCH] = prerot(sd.py, $signed({5'd0, sq_chain[SQRT_STEPS].root}));
    pre_nxt.ch[CH_BANK]  = prerot(sd.by, sd.bx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (adv) begin
      pre_valid_r <= pre_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r <= pre_nxt;
    end
  end

  always_comb begin
    cd_chain[0]       = pre_r;
    cd_chain[0].valid = pre_valid_r;
  end

  // cordic chain, three channels per cell
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    qte_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .step  (STEP_W'(i)),
      .d     (cd_chain[i]),
      .q     (cd_chain[i+1])
    );
  end

  // q20 angle to rounded signed q3.13 angle, magnitude clamped to the given limit, zero for a zero vector
  function automatic logic signed [ANG_W:0] to_q13(cch_t c, logic [16:0] lim);
    logic [Z_W-1:0] mag;
    logic [16:0]    r;
    mag = c.z[Z_W-1] ? Z_W'(-c.z) : Z_W'(c.z);
    r   = 17'((mag + Z_W'(64)) >> 7);
    if (r > lim) begin
      r = lim;
    end
    if (c.zero) begin
      r = '0;
    end
    return c.z[Z_W-1] ? -$signed(r) : $signed(r);
  endfunction

  cd_t                       fin;
  logic signed [ANG_W:0]     head_w, pitch_w, bank_w;
  logic signed [ANG_W-1:0]   heading_r, bank_r;
  logic signed [PITCH_W-1:0] pitch_r;
  logic                      locked_r;

  always_comb begin
    fin     = cd_chain[CORDIC_STEPS];
    head_w  = to_q13(fin.ch[CH_HEAD], PI_Q13);
    pitch_w = to_q13(fin.ch[CH_PITCH], HALF_PI_Q13);
    bank_w  = to_q13(fin.ch[CH_BANK], PI_Q13);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading_r <= head_w[ANG_W-1:0];
      pitch_r   <= fin.locked ? fin.pitch_lock : pitch_w[PITCH_W-1:0];
      bank_r    <= fin.locked ? '0 : bank_w[ANG_W-1:0];
      locked_r  <= fin.locked;
    end
  end

  assign out_euler.valid         = out_valid_r;
  assign out_euler.heading_angle = heading_r;
  assign out_euler.pitch_angle   = pitch_r;
  assign out_euler.bank_angle    = bank_r;
  assign out_euler.gimbal_locked = locked_r;

  // a locked result always has zero bank
  `QTE_ASSERT_IMP(a_lock_bank_zero, out_valid_r && locked_r, bank_r == '0)
  // pitch never leaves plus or minus pi/2
  `QTE_ASSERT_IMP(a_pitch_range, out_valid_r,
                  (pitch_r <= 15'sd12868) && (pitch_r >= -15'sd12868))
  // a valid item leaving the last cordic cell lands in the output register
  `QTE_ASSERT_NXT(a_out_load, adv && fin.valid, out_valid_r)

endmodule
